[sv/lfpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, constants and codes of the line-follow PD motor drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int SENSOR_BITS_DEFAULT = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int CMD_W   = 2;
    localparam int KNOB_W  = 12;
    localparam int GAIN_W  = 12;
    localparam int BASE_W  = 12;
    localparam int DRIVE_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [BASE_W-1:0]  BASE_SPEED_RESET = BASE_W'(40);
    localparam logic [DRIVE_W-1:0] MIN_DRIVE_RESET  = DRIVE_W'(0);
    localparam logic [DRIVE_W-1:0] MAX_DRIVE_RESET  = DRIVE_W'(100);

    // gains scaled so that control = (err*kp_raw + 2*diff*kd_raw) / GAIN_DIV
    localparam int GAIN_DIV = 4000;
    localparam int RECIP_SHIFT = 32;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / GAIN_DIV;
    localparam int RECIP_W = $clog2(RECIP_FULL + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    typedef enum logic [CMD_W-1:0] {
        CMD_PROP  = 2'd0,
        CMD_DERIV = 2'd1,
        CMD_BASE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DRIVE = 1'b0,
        CFG_MAX_DRIVE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [DRIVE_W-1:0] min_drive;
        logic [DRIVE_W-1:0] max_drive;
    } t_limits;

endpackage
`default_nettype wire

[sv/lfpd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module lfpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lfpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

[sv/lfpd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_front
// Takes sample items, applies the knob command and forms error and diff.
// ----------------------------------------------------------------------------
module lfpd_front #(
    parameter int SENSOR_BITS = lfpd_pkg::SENSOR_BITS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [SENSOR_BITS-1:0]        i_left_level,
    input  wire logic [SENSOR_BITS-1:0]        i_right_level,
    input  wire logic [lfpd_pkg::CMD_W-1:0]    i_command,
    input  wire logic [lfpd_pkg::KNOB_W-1:0]   i_knob_value,
    input  wire logic                          i_q_full,
    output logic                               o_full,
    output logic                               o_q_push,
    output logic signed [SENSOR_BITS:0]        o_error,
    output logic signed [SENSOR_BITS+1:0]      o_diff,
    output logic [lfpd_pkg::GAIN_W-1:0]        o_kp,
    output logic [lfpd_pkg::GAIN_W-1:0]        o_kd,
    output logic [lfpd_pkg::BASE_W-1:0]        o_base
);

    localparam int EW = SENSOR_BITS + 1;
    localparam int DW = SENSOR_BITS + 2;

    logic [lfpd_pkg::GAIN_W-1:0] r_kp, n_kp, r_kd, n_kd;
    logic [lfpd_pkg::BASE_W-1:0] r_base, n_base;
    logic signed [EW-1:0]        r_prev_err, error;
    logic                        accept;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    always_comb begin
        n_kp   = r_kp;
        n_kd   = r_kd;
        n_base = r_base;
        unique case (lfpd_pkg::t_cmd'(i_command))
            lfpd_pkg::CMD_PROP:  n_kp   = i_knob_value;
            lfpd_pkg::CMD_DERIV: n_kd   = i_knob_value;
            lfpd_pkg::CMD_BASE:  n_base = i_knob_value;
            lfpd_pkg::CMD_NONE:  n_kp   = r_kp;
        endcase
    end

    assign error   = $signed({1'b0, i_left_level}) - $signed({1'b0, i_right_level});
    assign o_error = error;
    assign o_diff  = DW'(error) - DW'(r_prev_err);
    assign o_kp    = n_kp;
    assign o_kd    = n_kd;
    assign o_base  = n_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= '0;
            r_kd       <= '0;
            r_base     <= lfpd_pkg::BASE_SPEED_RESET;
            r_prev_err <= '0;
        end else if (accept) begin
            r_kp       <= n_kp;
            r_kd       <= n_kd;
            r_base     <= n_base;
            r_prev_err <= error;
        end
    end

endmodule
`default_nettype wire

[sv/lfpd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_back
// PD control pipeline: gain products, divide by constant, speed split, clamp.
// ----------------------------------------------------------------------------
module lfpd_back #(
    parameter int SENSOR_BITS = lfpd_pkg::SENSOR_BITS_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lfpd_pkg::t_limits              i_limits,
    input  wire logic                           i_valid,
    input  wire logic signed [SENSOR_BITS:0]    i_error,
    input  wire logic signed [SENSOR_BITS+1:0]  i_diff,
    input  wire logic [lfpd_pkg::GAIN_W-1:0]    i_kp,
    input  wire logic [lfpd_pkg::GAIN_W-1:0]    i_kd,
    input  wire logic [lfpd_pkg::BASE_W-1:0]    i_base,
    output logic                                o_take,
    input  wire logic                           i_out_full,
    output logic                                o_valid,
    output logic [lfpd_pkg::DRIVE_W-1:0]        o_left_drive,
    output logic [lfpd_pkg::DRIVE_W-1:0]        o_right_drive
);

    localparam int DRW = lfpd_pkg::DRIVE_W;
    localparam int BW  = lfpd_pkg::BASE_W;
    localparam int P0W = SENSOR_BITS + 14;
    localparam int P1W = SENSOR_BITS + 15;
    localparam int NW  = SENSOR_BITS + 17;
    localparam int MW  = SENSOR_BITS + 16;
    localparam int RPW = MW + lfpd_pkg::RECIP_W;
    localparam int QW  = MW - $clog2(lfpd_pkg::GAIN_DIV) + 1;
    localparam int CW  = QW + 1;
    localparam int VW  = ((CW > BW + 1) ? CW : BW + 1) + 2;

    logic advance;

    logic                  r_a_valid;
    logic signed [P0W-1:0] r_a_p0;
    logic signed [P1W-1:0] r_a_p1;
    logic [BW-1:0]         r_a_base;

    logic                  r_b_valid, r_b_neg;
    logic [MW-1:0]         r_b_mag;
    logic [BW-1:0]         r_b_base;
    logic signed [NW-1:0]  num, num_abs;

    logic                  r_c_valid, r_c_neg;
    logic [MW-1:0]         r_c_mag;
    logic [QW-1:0]         r_c_q;
    logic [BW-1:0]         r_c_base;
    logic [RPW-1:0]        prod;

    logic                  r_d_valid, r_d_neg, r_d_ge;
    logic [QW-1:0]         r_d_q;
    logic [BW-1:0]         r_d_base;
    logic [MW-1:0]         qd, rem;

    logic                  r_e_valid;
    logic signed [CW-1:0]  r_e_control;
    logic signed [VW-1:0]  r_e_dyn;
    logic [QW-1:0]         q_fix;

    logic                  r_f_valid;
    logic [DRW-1:0]        r_f_left, r_f_right;

    function automatic logic [DRW-1:0] clamp_drive(input logic signed [VW-1:0] v,
                                                   input lfpd_pkg::t_limits lim);
        logic signed [VW-1:0] lo, hi;
        lo = $signed({{(VW-DRW){1'b0}}, lim.min_drive});
        hi = $signed({{(VW-DRW){1'b0}}, lim.max_drive});
        if (v < lo) begin
            clamp_drive = lim.min_drive;
        end else if (v > hi) begin
            clamp_drive = lim.max_drive;
        end else begin
            clamp_drive = v[DRW-1:0];
        end
    endfunction

    assign advance       = !r_f_valid || !i_out_full;
    assign o_take        = advance && i_valid;
    assign o_valid       = r_f_valid;
    assign o_left_drive  = r_f_left;
    assign o_right_drive = r_f_right;

    assign num     = NW'(r_a_p0) + (NW'(r_a_p1) <<< 1);
    assign num_abs = num[NW-1] ? -num : num;
    assign prod    = RPW'(r_b_mag) * RPW'(lfpd_pkg::RECIP);
    assign qd      = MW'(r_c_q) * MW'(lfpd_pkg::GAIN_DIV);
    assign rem     = r_c_mag - qd;
    assign q_fix   = r_d_q + QW'(r_d_ge);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            // gain products
            r_a_p0   <= P0W'(i_error) * P0W'($signed({1'b0, i_kp}));
            r_a_p1   <= P1W'(i_diff) * P1W'($signed({1'b0, i_kd}));
            r_a_base <= i_base;
            // sum and magnitude
            r_b_neg  <= num[NW-1];
            r_b_mag  <= num_abs[MW-1:0];
            r_b_base <= r_a_base;
            // reciprocal estimate, never above the true quotient
            r_c_q    <= prod[lfpd_pkg::RECIP_SHIFT +: QW];
            r_c_mag  <= r_b_mag;
            r_c_neg  <= r_b_neg;
            r_c_base <= r_b_base;
            // remainder check
            r_d_ge   <= (rem >= MW'(lfpd_pkg::GAIN_DIV));
            r_d_q    <= r_c_q;
            r_d_neg  <= r_c_neg;
            r_d_base <= r_c_base;
            // signed control and reduced speed
            r_e_control <= r_d_neg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
            r_e_dyn     <= VW'($signed({1'b0, r_d_base})) - VW'($signed({1'b0, q_fix >> 1}));
            // split and clamp
            r_f_left  <= clamp_drive(r_e_dyn - VW'(r_e_control), i_limits);
            r_f_right <= clamp_drive(r_e_dyn + VW'(r_e_control), i_limits);
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid && i_out_full |=> r_f_valid && $stable(r_f_left) && $stable(r_f_right))
        else $error("result changed while stalled");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> rem < MW'(2 * lfpd_pkg::GAIN_DIV))
        else $error("reciprocal estimate off by more than one");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid && (i_limits.min_drive <= i_limits.max_drive) |->
        r_f_left >= i_limits.min_drive && r_f_left <= i_limits.max_drive &&
        r_f_right >= i_limits.min_drive && r_f_right <= i_limits.max_drive)
        else $error("drive outside limits");

    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !r_f_valid |-> o_take)
        else $error("pipeline refused item with free output");

endmodule
`default_nettype wire

[sv/line_follow_pd_motor_drive_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_follow_pd_motor_drive_top
// PD line follower: sensor samples in, clamped left and right drives out.
//
// Input items arrive through a queue-style port: an item is taken at a clock
// edge where push is high and full is low. Each item may update one setting
// (proportional gain, derivative gain or base speed) from its knob value
// before the control step runs on it.
// Results leave through a queue-style port: while empty is low the oldest
// result sits on o_left_drive / o_right_drive and is taken when pop is high.
// Limits min_drive / max_drive are written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user must write them only while no item is in flight;
// the block itself does not enforce this. The six-stage control pipeline
// runs in lockstep and sustains one item per cycle while results are taken.
// A stalled receiver halts the pipeline; the front queue then fills and
// raises full. Reset clears gains and the stored error, sets base speed to 40
// and the limits to 0 and 100, and empties both queues.
// ----------------------------------------------------------------------------
module line_follow_pd_motor_drive_top #(
    parameter int SENSOR_BITS = lfpd_pkg::SENSOR_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = lfpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [SENSOR_BITS-1:0]          i_left_level,
    input  wire logic [SENSOR_BITS-1:0]          i_right_level,
    input  wire logic [lfpd_pkg::CMD_W-1:0]      i_command,
    input  wire logic [lfpd_pkg::KNOB_W-1:0]     i_knob_value,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [lfpd_pkg::DRIVE_W-1:0]         o_left_drive,
    output logic [lfpd_pkg::DRIVE_W-1:0]         o_right_drive,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lfpd_pkg::DRIVE_W-1:0]    i_cfg_data
);

    localparam int EW  = SENSOR_BITS + 1;
    localparam int DW  = SENSOR_BITS + 2;
    localparam int GW  = lfpd_pkg::GAIN_W;
    localparam int BW  = lfpd_pkg::BASE_W;
    localparam int DRW = lfpd_pkg::DRIVE_W;
    localparam int MQW = EW + DW + 2 * GW + BW;
    localparam int OQW = 2 * DRW;

    lfpd_pkg::t_limits r_limits;

    logic                 mq_push, mq_full, mq_empty, mq_pop;
    logic [MQW-1:0]       mq_wdata, mq_rdata;
    logic signed [EW-1:0] f_error, b_error;
    logic signed [DW-1:0] f_diff, b_diff;
    logic [GW-1:0]        f_kp, f_kd, b_kp, b_kd;
    logic [BW-1:0]        f_base, b_base;

    logic                 oq_full, b_valid;
    logic [DRW-1:0]       b_left, b_right;
    logic [OQW-1:0]       oq_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.min_drive <= lfpd_pkg::MIN_DRIVE_RESET;
            r_limits.max_drive <= lfpd_pkg::MAX_DRIVE_RESET;
        end else if (i_cfg_we) begin
            unique case (lfpd_pkg::t_cfg_idx'(i_cfg_index))
                lfpd_pkg::CFG_MIN_DRIVE: r_limits.min_drive <= i_cfg_data;
                lfpd_pkg::CFG_MAX_DRIVE: r_limits.max_drive <= i_cfg_data;
            endcase
        end
    end

    lfpd_front #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_left_level  (i_left_level),
        .i_right_level (i_right_level),
        .i_command     (i_command),
        .i_knob_value  (i_knob_value),
        .i_q_full      (mq_full),
        .o_full        (full),
        .o_q_push      (mq_push),
        .o_error       (f_error),
        .o_diff        (f_diff),
        .o_kp          (f_kp),
        .o_kd          (f_kd),
        .o_base        (f_base)
    );

    assign mq_wdata = {f_error, f_diff, f_kp, f_kd, f_base};

    lfpd_fifo #(
        .WIDTH (MQW),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .i_data  (mq_wdata),
        .o_full  (mq_full),
        .i_pop   (mq_pop),
        .o_data  (mq_rdata),
        .o_empty (mq_empty)
    );

    assign {b_error, b_diff, b_kp, b_kd, b_base} = mq_rdata;

    lfpd_back #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_limits      (r_limits),
        .i_valid       (!mq_empty),
        .i_error       (b_error),
        .i_diff        (b_diff),
        .i_kp          (b_kp),
        .i_kd          (b_kd),
        .i_base        (b_base),
        .o_take        (mq_pop),
        .i_out_full    (oq_full),
        .o_valid       (b_valid),
        .o_left_drive  (b_left),
        .o_right_drive (b_right)
    );

    lfpd_fifo #(
        .WIDTH (OQW),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid),
        .i_data  ({b_left, b_right}),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_rdata),
        .o_empty (empty)
    );

    assign o_left_drive  = oq_rdata[OQW-1:DRW];
    assign o_right_drive = oq_rdata[DRW-1:0];

endmodule
`default_nettype wire
